/* rtl/cau_pkg.sv */
// Shared types for the complex arithmetic unit: command and status codes
// and the control word that travels down the pipeline.
// No dependencies.
`default_nettype none

package cau_pkg;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIV_ZERO  = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
      logic    dz;
      logic    neg_r;
      logic    neg_i;
      logic    sat;
   } ctl_type;

endpackage

`default_nettype wire

/* rtl/cau_req_if.sv */
// Request channel of the complex arithmetic unit: command and two operands.
// Depends on nothing.
`default_nettype none

interface cau_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic signed [DATA_WIDTH-1:0] a_real;
   logic signed [DATA_WIDTH-1:0] a_imag;
   logic signed [DATA_WIDTH-1:0] b_real;
   logic signed [DATA_WIDTH-1:0] b_imag;

   modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

`default_nettype wire

/* rtl/cau_rsp_if.sv */
// Response channel of the complex arithmetic unit: result and status.
// Depends on nothing.
`default_nettype none

interface cau_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_real;
   logic signed [DATA_WIDTH-1:0] result_imag;
   logic [1:0]                   status;

   modport source (output valid, result_real, result_imag, status, input ready);
   modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

`default_nettype wire

/* rtl/cau_div_cell.sv */
// One quotient-bit cell of the divider chain: restoring step on two lanes.
// Depends on cau_pkg.
`default_nettype none

module cau_div_cell #(
   parameter int PW = 64,
   parameter int NW = 80,
   parameter int SW = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  wire cau_pkg::ctl_type  ctl_in,
   input  wire [PW-1:0]           den_in,
   input  wire [1:0][PW:0]        rem_in,
   input  wire [1:0][NW-1:0]      nq_in,
   input  wire [SW-1:0]           side_in,
   output cau_pkg::ctl_type       ctl_out,
   output logic [PW-1:0]          den_out,
   output logic [1:0][PW:0]       rem_out,
   output logic [1:0][NW-1:0]     nq_out,
   output logic [SW-1:0]          side_out
);

   cau_pkg::ctl_type    ctl_ff;
   logic [PW-1:0]       den_ff;
   logic [1:0][PW:0]    rem_ff, rem_in_w;
   logic [1:0][NW-1:0]  nq_ff, nq_in_w;
   logic [SW-1:0]       side_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         logic [PW:0]   sh;
         logic [PW+1:0] diff;
         sh   = {rem_in[k][PW-1:0], nq_in[k][NW-1]};
         diff = {1'b0, sh} - {2'b00, den_in};
         rem_in_w[k] = diff[PW+1] ? sh : diff[PW:0];
         nq_in_w[k]  = {nq_in[k][NW-2:0], ~diff[PW+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.cmd   <= ctl_in.cmd;
         ctl_ff.dz    <= ctl_in.dz;
         ctl_ff.neg_r <= ctl_in.neg_r;
         ctl_ff.neg_i <= ctl_in.neg_i;
         ctl_ff.sat   <= ctl_in.sat;
         den_ff       <= den_in;
         rem_ff       <= rem_in_w;
         nq_ff        <= nq_in_w;
         side_ff      <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign nq_out   = nq_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

/* rtl/complex_arithmetic_unit_core.sv */
// Top level of the complex arithmetic unit: operand pipeline, divider chain
// and response register. Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_div_cell.
//
// Usage:
//   req_chan carries one word per operation: command (add, subtract, multiply,
//   divide) and the operands a and b, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
//   rsp_chan returns one word per request, in order: result parts and status
//   (ok, divide by zero, saturated).
//   Every command passes through four operand stages (products, sums, magnitudes,
//   packing), one divider cell per quotient bit, then the response register.
//   Throughput is one word per cycle while rsp_chan does not stall; the divider
//   chain holds one operation in each cell, so a new word is taken every cycle
//   while results drain.
//   When rsp_chan stalls with a word waiting, the whole pipeline holds and
//   req_chan.ready drops until that word is taken.
//   Reset clears all valid bits; operand and result data are not reset.
`default_nettype none

module complex_arithmetic_unit_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input wire        clock,
   input wire        reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int PW = 2 * DW;
   localparam int XW = 2 * DW + 1;
   localparam int NW = 2 * DW + FB;
   localparam int SW = 2 * DW;

   function automatic logic [DW:0] sat_pack(input logic neg, input logic [NW-1:0] mag);
      logic [NW-1:0] half;
      logic [NW-1:0] lim;
      logic [NW-1:0] m;
      logic          s;
      half = NW'(1) << (DW - 1);
      lim  = neg ? half : half - NW'(1);
      s    = mag > lim;
      m    = s ? lim : mag;
      sat_pack = {s, neg ? DW'(NW'(0) - m) : DW'(m)};
   endfunction

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // products and add/sub
   cau_pkg::ctl_type        s1_ctl_ff, s1_ctl_in;
   logic signed [PW-1:0]    s1_ac_ff, s1_bd_ff, s1_ad_ff, s1_bc_ff, s1_cc_ff, s1_dd_ff;
   logic signed [XW-1:0]    s1_sr_ff, s1_si_ff, s1_sr_in, s1_si_in;

   always_comb begin
      s1_ctl_in       = '0;
      s1_ctl_in.valid = req_chan.valid;
      s1_ctl_in.cmd   = cau_pkg::cmd_type'(req_chan.command);
      s1_ctl_in.dz    = (req_chan.b_real == '0) && (req_chan.b_imag == '0);
      if (s1_ctl_in.cmd == cau_pkg::CMD_SUB) begin
         s1_sr_in = XW'(req_chan.a_real) - XW'(req_chan.b_real);
         s1_si_in = XW'(req_chan.a_imag) - XW'(req_chan.b_imag);
      end else begin
         s1_sr_in = XW'(req_chan.a_real) + XW'(req_chan.b_real);
         s1_si_in = XW'(req_chan.a_imag) + XW'(req_chan.b_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
      end
      if (en) begin
         s1_ctl_ff.cmd   <= s1_ctl_in.cmd;
         s1_ctl_ff.dz    <= s1_ctl_in.dz;
         s1_ctl_ff.neg_r <= 1'b0;
         s1_ctl_ff.neg_i <= 1'b0;
         s1_ctl_ff.sat   <= 1'b0;
         s1_ac_ff <= PW'(req_chan.a_real) * PW'(req_chan.b_real);
         s1_bd_ff <= PW'(req_chan.a_imag) * PW'(req_chan.b_imag);
         s1_ad_ff <= PW'(req_chan.a_real) * PW'(req_chan.b_imag);
         s1_bc_ff <= PW'(req_chan.a_imag) * PW'(req_chan.b_real);
         s1_cc_ff <= PW'(req_chan.b_real) * PW'(req_chan.b_real);
         s1_dd_ff <= PW'(req_chan.b_imag) * PW'(req_chan.b_imag);
         s1_sr_ff <= s1_sr_in;
         s1_si_ff <= s1_si_in;
      end
   end

   // sums of products and divisor
   cau_pkg::ctl_type     s2_ctl_ff;
   logic signed [XW-1:0] s2_xr_ff, s2_xi_ff, s2_xr_in, s2_xi_in;
   logic [PW-1:0]        s2_den_ff;

   always_comb begin
      unique case (s1_ctl_ff.cmd)
         cau_pkg::CMD_MUL: begin
            s2_xr_in = XW'(s1_ac_ff) - XW'(s1_bd_ff);
            s2_xi_in = XW'(s1_ad_ff) + XW'(s1_bc_ff);
         end
         cau_pkg::CMD_DIV: begin
            s2_xr_in = XW'(s1_ac_ff) + XW'(s1_bd_ff);
            s2_xi_in = XW'(s1_bc_ff) - XW'(s1_ad_ff);
         end
         default: begin
            s2_xr_in = s1_sr_ff;
            s2_xi_in = s1_si_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
      end
      if (en) begin
         s2_ctl_ff.cmd   <= s1_ctl_ff.cmd;
         s2_ctl_ff.dz    <= s1_ctl_ff.dz;
         s2_ctl_ff.neg_r <= 1'b0;
         s2_ctl_ff.neg_i <= 1'b0;
         s2_ctl_ff.sat   <= 1'b0;
         s2_xr_ff  <= s2_xr_in;
         s2_xi_ff  <= s2_xi_in;
         s2_den_ff <= $unsigned(s1_cc_ff) + $unsigned(s1_dd_ff);
      end
   end

   // sign and magnitude
   cau_pkg::ctl_type s3_ctl_ff;
   logic [XW-1:0]    s3_mr_ff, s3_mi_ff, s3_mr_in, s3_mi_in;
   logic [PW-1:0]    s3_den_ff;

   always_comb begin
      s3_mr_in = s2_xr_ff[XW-1] ? XW'(-s2_xr_ff) : XW'(s2_xr_ff);
      s3_mi_in = s2_xi_ff[XW-1] ? XW'(-s2_xi_ff) : XW'(s2_xi_ff);
      if (s2_ctl_ff.cmd == cau_pkg::CMD_MUL) begin
         s3_mr_in = s3_mr_in >> FB;
         s3_mi_in = s3_mi_in >> FB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
      end
      if (en) begin
         s3_ctl_ff.cmd   <= s2_ctl_ff.cmd;
         s3_ctl_ff.dz    <= s2_ctl_ff.dz;
         s3_ctl_ff.neg_r <= s2_xr_ff[XW-1];
         s3_ctl_ff.neg_i <= s2_xi_ff[XW-1];
         s3_ctl_ff.sat   <= 1'b0;
         s3_mr_ff  <= s3_mr_in;
         s3_mi_ff  <= s3_mi_in;
         s3_den_ff <= s2_den_ff;
      end
   end

   // pack add/sub/mul results, load dividends
   cau_pkg::ctl_type   s4_ctl_ff;
   logic [PW-1:0]      s4_den_ff;
   logic [1:0][NW-1:0] s4_nq_ff;
   logic [SW-1:0]      s4_side_ff;
   logic [DW:0]        pk_r, pk_i;

   assign pk_r = sat_pack(s3_ctl_ff.neg_r, NW'(s3_mr_ff));
   assign pk_i = sat_pack(s3_ctl_ff.neg_i, NW'(s3_mi_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s4_ctl_ff.valid <= s3_ctl_ff.valid;
      end
      if (en) begin
         s4_ctl_ff.cmd   <= s3_ctl_ff.cmd;
         s4_ctl_ff.dz    <= s3_ctl_ff.dz;
         s4_ctl_ff.neg_r <= s3_ctl_ff.neg_r;
         s4_ctl_ff.neg_i <= s3_ctl_ff.neg_i;
         s4_ctl_ff.sat   <= pk_r[DW] | pk_i[DW];
         s4_den_ff       <= s3_den_ff;
         s4_nq_ff[0]     <= {s3_mr_ff[PW-1:0], {FB{1'b0}}};
         s4_nq_ff[1]     <= {s3_mi_ff[PW-1:0], {FB{1'b0}}};
         s4_side_ff      <= {pk_r[DW-1:0], pk_i[DW-1:0]};
      end
   end

   // divider chain, one cell per quotient bit
   cau_pkg::ctl_type   ch_ctl  [NW+1];
   logic [PW-1:0]      ch_den  [NW+1];
   logic [1:0][PW:0]   ch_rem  [NW+1];
   logic [1:0][NW-1:0] ch_nq   [NW+1];
   logic [SW-1:0]      ch_side [NW+1];

   assign ch_ctl[0]  = s4_ctl_ff;
   assign ch_den[0]  = s4_den_ff;
   assign ch_rem[0]  = '0;
   assign ch_nq[0]   = s4_nq_ff;
   assign ch_side[0] = s4_side_ff;

   for (genvar g = 0; g < NW; g++) begin : g_cell
      cau_div_cell #(
         .PW (PW),
         .NW (NW),
         .SW (SW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in   (ch_ctl[g]),
         .den_in   (ch_den[g]),
         .rem_in   (ch_rem[g]),
         .nq_in    (ch_nq[g]),
         .side_in  (ch_side[g]),
         .ctl_out  (ch_ctl[g+1]),
         .den_out  (ch_den[g+1]),
         .rem_out  (ch_rem[g+1]),
         .nq_out   (ch_nq[g+1]),
         .side_out (ch_side[g+1])
      );
   end

   // response register
   cau_pkg::ctl_type     fin_ctl;
   logic [DW:0]          qk_r, qk_i;
   logic [DW-1:0]        rsp_real_ff, rsp_real_in, rsp_imag_ff, rsp_imag_in;
   cau_pkg::status_type  rsp_status_ff, rsp_status_in;

   assign fin_ctl = ch_ctl[NW];
   assign qk_r = sat_pack(fin_ctl.neg_r, ch_nq[NW][0]);
   assign qk_i = sat_pack(fin_ctl.neg_i, ch_nq[NW][1]);

   always_comb begin
      if (fin_ctl.cmd != cau_pkg::CMD_DIV) begin
         rsp_real_in   = ch_side[NW][SW-1:DW];
         rsp_imag_in   = ch_side[NW][DW-1:0];
         rsp_status_in = fin_ctl.sat ? cau_pkg::ST_SATURATED : cau_pkg::ST_OK;
      end else if (fin_ctl.dz) begin
         rsp_real_in   = '0;
         rsp_imag_in   = '0;
         rsp_status_in = cau_pkg::ST_DIV_ZERO;
      end else begin
         rsp_real_in   = qk_r[DW-1:0];
         rsp_imag_in   = qk_i[DW-1:0];
         rsp_status_in = (qk_r[DW] | qk_i[DW]) ? cau_pkg::ST_SATURATED : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fin_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_real_ff   <= rsp_real_in;
         rsp_imag_ff   <= rsp_imag_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_real = rsp_real_ff;
   assign rsp_chan.result_imag = rsp_imag_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == cau_pkg::ST_DIV_ZERO) |->
         (rsp_chan.result_real == '0 && rsp_chan.result_imag == '0))
      else $error("divide by zero with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == cau_pkg::ST_OK ||
         rsp_chan.status == cau_pkg::ST_DIV_ZERO || rsp_chan.status == cau_pkg::ST_SATURATED))
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

/* tb/sv/cau_result_checker.sv */
// Result checker for the complex arithmetic unit: watches both channels,
// computes the expected result of every accepted request and compares.
// Depends on cau_pkg, cau_req_if, cau_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module cau_result_checker #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire       clock,
   input  wire       reset,
   cau_req_if        req_chan,
   cau_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count,
   output int        checked_count,
   output int        div_zero_count,
   output int        saturated_count
);

   typedef struct {
      logic signed [DATA_WIDTH-1:0] res_real;
      logic signed [DATA_WIDTH-1:0] res_imag;
      cau_pkg::status_type          status;
   } cau_result_type;

   localparam logic signed [127:0] MAX_VAL = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
   localparam logic signed [127:0] MIN_VAL = -(128'sd1 <<< (DATA_WIDTH - 1));

   cau_result_type expected_results[$];

   function automatic logic signed [DATA_WIDTH-1:0] clamp_part(
      input logic signed [127:0] value, inout logic sat);
      if (value > MAX_VAL) begin
         sat = 1'b1;
         return MAX_VAL[DATA_WIDTH-1:0];
      end
      if (value < MIN_VAL) begin
         sat = 1'b1;
         return MIN_VAL[DATA_WIDTH-1:0];
      end
      return value[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [127:0] shift_toward_zero(input logic signed [127:0] v);
      logic [127:0] mag;
      mag = (v < 0) ? -v : v;
      mag = mag >> FRAC_BITS;
      return (v < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [127:0] divide_toward_zero(
      input logic signed [127:0] num, input logic [127:0] den);
      logic [127:0] mag;
      mag = (num < 0) ? -num : num;
      mag = (mag << FRAC_BITS) / den;
      return (num < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic cau_result_type compute_result(
      input cau_pkg::cmd_type op,
      input logic signed [DATA_WIDTH-1:0] ar, ai, br, bi);
      cau_result_type r;
      logic signed [127:0] xr, xi, ear, eai, ebr, ebi;
      logic [127:0] den;
      logic sat;
      sat = 1'b0;
      ear = ar;
      eai = ai;
      ebr = br;
      ebi = bi;
      r.status = cau_pkg::ST_OK;
      case (op)
         cau_pkg::CMD_ADD: begin
            xr = ear + ebr;
            xi = eai + ebi;
         end
         cau_pkg::CMD_SUB: begin
            xr = ear - ebr;
            xi = eai - ebi;
         end
         cau_pkg::CMD_MUL: begin
            xr = shift_toward_zero(ear * ebr - eai * ebi);
            xi = shift_toward_zero(ear * ebi + eai * ebr);
         end
         default: begin
            if (br == 0 && bi == 0) begin
               xr = 0;
               xi = 0;
               r.status = cau_pkg::ST_DIV_ZERO;
            end else begin
               den = ebr * ebr + ebi * ebi;
               xr = divide_toward_zero(ear * ebr + eai * ebi, den);
               xi = divide_toward_zero(eai * ebr - ear * ebi, den);
            end
         end
      endcase
      r.res_real = clamp_part(xr, sat);
      r.res_imag = clamp_part(xi, sat);
      if (sat && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_SATURATED;
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
      div_zero_count = 0;
      saturated_count = 0;
   end

   always @(posedge clock) begin
      cau_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(compute_result(cau_pkg::cmd_type'(req_chan.command),
               req_chan.a_real, req_chan.a_imag, req_chan.b_real, req_chan.b_imag));
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked_count++;
            if (rsp_chan.status == cau_pkg::ST_DIV_ZERO) div_zero_count++;
            if (rsp_chan.status == cau_pkg::ST_SATURATED) saturated_count++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("error: unexpected result word real=%h imag=%h status=%0d",
                     rsp_chan.result_real, rsp_chan.result_imag, rsp_chan.status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.result_real !== want.res_real
                     || rsp_chan.result_imag !== want.res_imag
                     || rsp_chan.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("error: word %0d expected %h %h %0d got %h %h %0d",
                        checked_count, want.res_real, want.res_imag, want.status,
                        rsp_chan.result_real, rsp_chan.result_imag, rsp_chan.status);
               end
            end
         end
         pending_count = expected_results.size();
      end
   end
endmodule

`default_nettype wire

/* tb/sv/tb_complex_arithmetic_unit_core.sv */
// Top of the complex arithmetic unit testbench: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_result_checker and the core.
`timescale 1ns / 1ps
`default_nettype none

module tb_complex_arithmetic_unit_core;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_RANDOM = 1500;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [DATA_WIDTH-1:0] MAX_W = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] ONE_W = 1 <<< FRAC_BITS;

   logic clock;
   logic reset;
   logic no_gaps;
   int   fail_count, pending_count, checked_count, div_zero_count, saturated_count;
   int   sent_count;
   int   cycle_count;

   cau_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_chan ();
   cau_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_chan ();

   complex_arithmetic_unit_core #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   cau_result_checker #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .div_zero_count (div_zero_count),
      .saturated_count(saturated_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
         end
      end
   end

   // hold ready low for a random stall after each word, or not at all when quiet
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_word(input cau_pkg::cmd_type op,
      input logic signed [DATA_WIDTH-1:0] ar, ai, br, bi);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= op;
      req_chan.a_real  <= ar;
      req_chan.a_imag  <= ai;
      req_chan.b_real  <= br;
      req_chan.b_imag  <= bi;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return MAX_W;
         1:       return MIN_W;
         2:       return 0;
         3, 4:    return $urandom();
         5, 6:    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      endcase
   endfunction

   initial begin
      cau_pkg::cmd_type op;
      logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
      reset = 1'b1;
      no_gaps = 1'b0;
      sent_count = 0;
      req_chan.valid   <= 1'b0;
      req_chan.command <= cau_pkg::CMD_ADD;
      req_chan.a_real  <= '0;
      req_chan.a_imag  <= '0;
      req_chan.b_real  <= '0;
      req_chan.b_imag  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(cau_pkg::CMD_ADD, 0, 0, 0, 0);
      send_word(cau_pkg::CMD_ADD, MAX_W, MIN_W, MAX_W, MIN_W);
      send_word(cau_pkg::CMD_ADD, MAX_W, MIN_W, MIN_W, MAX_W);
      send_word(cau_pkg::CMD_SUB, MIN_W, MAX_W, MAX_W, MIN_W);
      send_word(cau_pkg::CMD_SUB, MIN_W, 0, MIN_W, -1);
      send_word(cau_pkg::CMD_MUL, ONE_W, ONE_W, ONE_W, -ONE_W);
      send_word(cau_pkg::CMD_MUL, MIN_W, MIN_W, MIN_W, MIN_W);
      send_word(cau_pkg::CMD_MUL, MAX_W, MAX_W, MIN_W, MAX_W);
      send_word(cau_pkg::CMD_MUL, -1, 1, 1, 1);
      send_word(cau_pkg::CMD_MUL, -3, 0, 1, 0);
      send_word(cau_pkg::CMD_DIV, ONE_W, -ONE_W, 0, 0);
      send_word(cau_pkg::CMD_DIV, MAX_W, MIN_W, 0, 0);
      send_word(cau_pkg::CMD_DIV, ONE_W, ONE_W, ONE_W, 0);
      send_word(cau_pkg::CMD_DIV, MAX_W, MAX_W, 1, 0);
      send_word(cau_pkg::CMD_DIV, MIN_W, MIN_W, 0, -1);
      send_word(cau_pkg::CMD_DIV, -1, 0, 3, 0);
      send_word(cau_pkg::CMD_DIV, 0, 0, MIN_W, MIN_W);
      send_word(cau_pkg::CMD_DIV, MAX_W, MIN_W, MAX_W, MAX_W);
      send_word(cau_pkg::CMD_SUB, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
         32'sh5555_5555);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 250 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         op = cau_pkg::cmd_type'($urandom_range(0, 3));
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if (op == cau_pkg::CMD_DIV && $urandom_range(0, 9) == 0) begin
            br = 0;
            bi = 0;
         end
         send_word(op, ar, ai, br, bi);
      end
      req_chan.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (2 * DATA_WIDTH + FRAC_BITS + 20) @(posedge clock);
      $display("sent %0d requests, checked %0d results", sent_count, checked_count);
      $display("divide by zero %0d, saturated %0d", div_zero_count, saturated_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_count);
         $display("FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire
